FILE: hw/rtl/tlnt_pkg.sv
// ----------------------------------------------------------------------------
// tlnt_pkg
// Shared types, sizes and codes of the two-level name table.
// ----------------------------------------------------------------------------
package tlnt_pkg;

    // table geometry
    localparam int MAX_GROUPS  = 16;
    localparam int MAX_ENTRIES = 16;

    // key and result field widths
    localparam int KEY_W   = 64;
    localparam int IDX_OUT = 4;

    // group index, group count, entry index, entry count
    localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW = $clog2(MAX_GROUPS + 1);
    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ECW = $clog2(MAX_ENTRIES + 1);

    // scan counter covers both group and entry scans
    localparam int SCW = (GCW > ECW) ? GCW : ECW;

    // memory depths, entry store is addressed by {group, slot}
    localparam int GRP_DEPTH = 1 << GIW;
    localparam int ENT_DEPTH = 1 << (GIW + EIW);

    // request opcodes
    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } t_opcode;

    // result status codes
    typedef enum logic [2:0] {
        ST_CREATED     = 3'd0,
        ST_ADDED       = 3'd1,
        ST_DELETED     = 3'd2,
        ST_FOUND       = 3'd3,
        ST_GROUPS_FULL = 3'd4,
        ST_NO_GROUP    = 3'd5,
        ST_NO_ENTRY    = 3'd6
    } t_status;

    // request word
    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] group_key;
        logic [KEY_W-1:0] entry_key;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [2:0]         status;
        logic [IDX_OUT-1:0] group_index;
        logic [IDX_OUT-1:0] entry_index;
    } t_out_word;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CREATE,
        DP_SCAN,
        DP_GHIT,
        DP_EHIT,
        DP_ADD,
        DP_DEL_RD,
        DP_DEL_WR,
        DP_OUT
    } t_dp_op;

    // controller to datapath
    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    groups_full;
        logic    group_full;
        logic    hit;
        logic    miss;
        logic    out_busy;
    } t_dp_sts;

endpackage

FILE: hw/rtl/two_level_name_table_top.sv
// ----------------------------------------------------------------------------
// two_level_name_table_top
// Two-level name table: groups of up to MAX_ENTRIES 64-bit entry names.
//
// Input channel (i_in_valid / o_in_stall / i_in) takes one request word:
// opcode, group key and entry key. Output channel (o_out_valid /
// i_out_stall / o_out) gives exactly one result word per request: status,
// group index and entry index.
// One request is worked on at a time, in steps: load, dispatch, group scan
// (all but create), entry check (add updates here), entry scan (search and
// delete), the delete read and write that move the last slot down, and the
// result step. A miss, a full table or a full group goes straight to the
// result step. The group and entry scans read one stored key per cycle from
// their store's read port and compare it in the next cycle. The next request
// is taken once the result step has loaded the result word.
// The result register lets the next request be accepted while a result
// waits; a stalled receiver holds the result word unchanged and the next
// request then waits in its final step until the word is taken.
// Reset empties the table (group count zero) and clears the output valid;
// the name stores need no clearing.
// ----------------------------------------------------------------------------
module two_level_name_table_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tlnt_pkg::t_in_word   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tlnt_pkg::t_out_word  o_out
);
    import tlnt_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // request sequencer
    tlnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // stores and scan datapath
    tlnt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

FILE: hw/rtl/tlnt_ram.sv
// ----------------------------------------------------------------------------
// tlnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlnt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tlnt_datapath.sv
// ----------------------------------------------------------------------------
// tlnt_datapath
// Key registers, counts, group and entry stores, scan engine and result word.
// ----------------------------------------------------------------------------
module tlnt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlnt_pkg::t_in_word i_in,
    input  tlnt_pkg::t_dp_cmd  i_cmd,
    input  logic               i_out_stall,
    output tlnt_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    output tlnt_pkg::t_out_word o_out
);
    import tlnt_pkg::*;

    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_gkey;
    logic [KEY_W-1:0] r_ekey;
    logic [GCW-1:0]   r_gcount;
    logic [ECW-1:0]   r_ecount [MAX_GROUPS];
    logic [GIW-1:0]   r_gsel;
    logic [EIW-1:0]   r_esel;
    logic [SCW-1:0]   r_scan_idx;
    logic [SCW-1:0]   r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_scan_ent;
    logic             r_out_vld;
    t_out_word        r_out;

    logic [ECW-1:0]       cnt;
    logic [ECW-1:0]       cnt_m1;
    logic [SCW-1:0]       limit;
    logic                 issue;
    logic [KEY_W-1:0]     grp_rdata;
    logic [KEY_W-1:0]     ent_rdata;
    logic [KEY_W-1:0]     cmp_data;
    logic [KEY_W-1:0]     cmp_key;
    logic                 grp_we;
    logic                 ent_we;
    logic [GIW+EIW-1:0]   ent_waddr;
    logic [GIW+EIW-1:0]   ent_raddr;
    logic [KEY_W-1:0]     ent_wdata;
    logic                 out_busy;

    // entry count of the selected group and scan bound
    assign cnt    = r_ecount[r_gsel];
    assign cnt_m1 = cnt - ECW'(1);
    assign limit  = r_scan_ent ? SCW'(cnt) : SCW'(r_gcount);
    assign issue  = (i_cmd.op == DP_SCAN) && (r_scan_idx < limit);

    // compare the word read in the previous scan cycle
    assign cmp_data = r_scan_ent ? ent_rdata : grp_rdata;
    assign cmp_key  = r_scan_ent ? r_ekey : r_gkey;

    // group name store
    assign grp_we = (i_cmd.op == DP_CREATE);

    tlnt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (GRP_DEPTH)
    ) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (grp_we),
        .i_waddr (r_gcount[GIW-1:0]),
        .i_wdata (r_gkey),
        .i_raddr (r_scan_idx[GIW-1:0]),
        .o_rdata (grp_rdata)
    );

    // entry name store, add appends, delete moves the last slot down
    assign ent_we    = (i_cmd.op == DP_ADD) || (i_cmd.op == DP_DEL_WR);
    assign ent_waddr = (i_cmd.op == DP_ADD) ? {r_gsel, cnt[EIW-1:0]} : {r_gsel, r_esel};
    assign ent_wdata = (i_cmd.op == DP_ADD) ? r_ekey : ent_rdata;
    assign ent_raddr = (i_cmd.op == DP_DEL_RD) ? {r_gsel, cnt_m1[EIW-1:0]}
                                               : {r_gsel, r_scan_idx[EIW-1:0]};

    tlnt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // group count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcount <= '0;
        end else if (i_cmd.op == DP_CREATE) begin
            r_gcount <= r_gcount + GCW'(1);
        end
    end

    // request registers, per-group counts and scan engine
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_op       <= i_in.opcode;
                r_gkey     <= i_in.group_key;
                r_ekey     <= i_in.entry_key;
                r_gsel     <= '0;
                r_esel     <= '0;
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
                r_scan_ent <= 1'b0;
            end
            DP_SCAN: begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_cmp_idx  <= r_scan_idx;
                    r_scan_idx <= r_scan_idx + SCW'(1);
                end
            end
            DP_GHIT: begin
                r_gsel     <= r_cmp_idx[GIW-1:0];
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
                r_scan_ent <= 1'b1;
            end
            DP_EHIT: begin
                r_esel    <= r_cmp_idx[EIW-1:0];
                r_cmp_vld <= 1'b0;
            end
            DP_CREATE: begin
                r_gsel                       <= r_gcount[GIW-1:0];
                r_ecount[r_gcount[GIW-1:0]] <= '0;
            end
            DP_ADD: begin
                r_esel           <= cnt[EIW-1:0];
                r_ecount[r_gsel] <= cnt + ECW'(1);
            end
            DP_DEL_RD: begin
                r_ecount[r_gsel] <= cnt_m1;
            end
            default: begin
            end
        endcase
    end

    // result register, refilled once the previous word has left
    assign out_busy = r_out_vld && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.op == DP_OUT) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_OUT) begin
            r_out.status      <= i_cmd.status;
            r_out.group_index <= IDX_OUT'(r_gsel);
            r_out.entry_index <= IDX_OUT'(r_esel);
        end
    end

    // status toward the controller
    assign o_sts.op          = t_opcode'(r_op);
    assign o_sts.groups_full = (r_gcount == GCW'(MAX_GROUPS));
    assign o_sts.group_full  = (cnt == ECW'(MAX_ENTRIES));
    assign o_sts.hit         = r_cmp_vld && (cmp_data == cmp_key);
    assign o_sts.miss        = !r_cmp_vld && !(r_scan_idx < limit);
    assign o_sts.out_busy    = out_busy;

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

FILE: hw/rtl/tlnt_ctrl.sv
// ----------------------------------------------------------------------------
// tlnt_ctrl
// Request sequencer: dispatch, group scan, entry scan, update and result.
// ----------------------------------------------------------------------------
module tlnt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tlnt_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output tlnt_pkg::t_dp_cmd o_cmd
);
    import tlnt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_GSCAN,
        S_ECHK,
        S_ESCAN,
        S_DEL_RD,
        S_DEL_WR,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;

    // next state, result code and datapath command
    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd.op     = DP_NOP;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.op == OP_CREATE) begin
                    n_state = S_FINISH;
                    if (i_sts.groups_full) begin
                        n_status = ST_GROUPS_FULL;
                    end else begin
                        o_cmd.op = DP_CREATE;
                        n_status = ST_CREATED;
                    end
                end else begin
                    n_state = S_GSCAN;
                end
            end
            S_GSCAN: begin
                if (i_sts.hit) begin
                    o_cmd.op = DP_GHIT;
                    n_state  = S_ECHK;
                end else if (i_sts.miss) begin
                    n_status = ST_NO_GROUP;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = DP_SCAN;
                end
            end
            S_ECHK: begin
                if (i_sts.op == OP_ADD) begin
                    n_state = S_FINISH;
                    if (i_sts.group_full) begin
                        n_status = ST_NO_GROUP;
                    end else begin
                        o_cmd.op = DP_ADD;
                        n_status = ST_ADDED;
                    end
                end else begin
                    n_state = S_ESCAN;
                end
            end
            S_ESCAN: begin
                if (i_sts.hit) begin
                    o_cmd.op = DP_EHIT;
                    if (i_sts.op == OP_SEARCH) begin
                        n_status = ST_FOUND;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_DEL_RD;
                    end
                end else if (i_sts.miss) begin
                    n_status = ST_NO_ENTRY;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = DP_SCAN;
                end
            end
            S_DEL_RD: begin
                o_cmd.op = DP_DEL_RD;
                n_state  = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_cmd.op = DP_DEL_WR;
                n_status = ST_DELETED;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_CREATED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/tlnt_checker.sv
// ----------------------------------------------------------------------------
// tlnt_checker
// Port-level checks of the name table, bound to the top level.
// ----------------------------------------------------------------------------
module tlnt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tlnt_pkg::t_out_word o_out
);
    import tlnt_pkg::*;

    // a stalled result word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result word changed while stalled");

    // one request at a time: an accepted word closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in progress");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status <= 3'(ST_NO_ENTRY)))
        else $error("undefined status code");

    // failures report no entry slot, a full table no group either
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == 3'(ST_GROUPS_FULL) ||
                        o_out.status == 3'(ST_NO_GROUP) ||
                        o_out.status == 3'(ST_NO_ENTRY))
        |-> (o_out.entry_index == '0) &&
            (o_out.status != 3'(ST_GROUPS_FULL) || o_out.group_index == '0))
        else $error("failed request reports an index");

endmodule

bind two_level_name_table_top tlnt_checker u_tlnt_checker (.*);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level name table.
// A short table of directed requests walks the empty table, the extreme keys,
// duplicate names and the delete-with-move cases. Random batches follow that
// fill, drain or mix the groups. Each accepted request runs through a model
// of the table kept here, and every result word is checked in order against
// it or a typed-in result. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlnt_pkg::*;

    localparam int DIR_ROWS     = 23;
    localparam int RANDOM_ITEMS = 1750;
    localparam int GRP_POOL     = 8;
    localparam int ENT_POOL     = 10;
    localparam int MAX_PRINTS   = 40;

    // readable extreme and sample keys
    localparam logic [KEY_W-1:0] KEY_ZERO = {KEY_W{1'b0}};
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] GRP_A    = 64'h616c_7068_6100_0000;
    localparam logic [KEY_W-1:0] GRP_B    = 64'h6265_7461_0000_0000;
    localparam logic [KEY_W-1:0] ENT_X    = 64'h696e_6465_7800_0000;
    localparam logic [KEY_W-1:0] ENT_Y    = 64'h6e6f_7465_7300_0000;

    // request mix of one random batch
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_MIXED
    } t_mix;

    // one directed request, with a typed-in result where it is obvious
    typedef struct {
        t_opcode          op;
        logic [KEY_W-1:0] gkey;
        logic [KEY_W-1:0] ekey;
        bit               typed;
        t_out_word        want;
    } t_dir_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // side data that travels with the request word
    bit        in_typed = 1'b0;
    t_out_word in_want = '0;

    // model copy of the table
    bit [KEY_W-1:0] grp_name [MAX_GROUPS];
    int             grp_count = 0;
    int             ent_count [MAX_GROUPS];
    bit [KEY_W-1:0] ent_name [MAX_GROUPS][MAX_ENTRIES];

    t_out_word      pending_results[$];
    logic [KEY_W-1:0] grp_pool [GRP_POOL];
    logic [KEY_W-1:0] ent_pool [ENT_POOL];
    t_dir_row       dir_rows [DIR_ROWS];

    int mismatches = 0;
    int results_checked = 0;
    int random_sent = 0;
    int status_seen [8];

    two_level_name_table_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        #2_600_000;
        $display("TB_ERROR");
        $finish;
    end

    // apply one request to the model table and return its result word
    function automatic t_out_word table_update(t_in_word req);
        t_out_word res;
        int        g;
        int        e;
        int        hit_g;
        int        hit_e;
        res = '0;
        res.status = ST_NO_GROUP;
        if (req.opcode == OP_CREATE) begin
            if (grp_count < MAX_GROUPS) begin
                grp_name[grp_count] = req.group_key;
                ent_count[grp_count] = 0;
                res.group_index = IDX_OUT'(grp_count);
                grp_count++;
                res.status = ST_CREATED;
            end else begin
                res.status = ST_GROUPS_FULL;
            end
        end else begin
            hit_g = -1;
            for (g = 0; g < grp_count; g++) begin
                if (hit_g < 0 && grp_name[g] == req.group_key) hit_g = g;
            end
            if (hit_g >= 0) begin
                res.group_index = IDX_OUT'(hit_g);
                if (req.opcode == OP_ADD) begin
                    // a full group keeps the group-miss status
                    if (ent_count[hit_g] < MAX_ENTRIES) begin
                        res.entry_index = IDX_OUT'(ent_count[hit_g]);
                        ent_name[hit_g][ent_count[hit_g]] = req.entry_key;
                        ent_count[hit_g]++;
                        res.status = ST_ADDED;
                    end
                end else begin
                    hit_e = -1;
                    for (e = 0; e < ent_count[hit_g]; e++) begin
                        if (hit_e < 0 && ent_name[hit_g][e] == req.entry_key) hit_e = e;
                    end
                    if (hit_e >= 0) begin
                        res.entry_index = IDX_OUT'(hit_e);
                        if (req.opcode == OP_DELETE) begin
                            // last entry moves into the freed slot
                            ent_count[hit_g]--;
                            ent_name[hit_g][hit_e] = ent_name[hit_g][ent_count[hit_g]];
                            res.status = ST_DELETED;
                        end else begin
                            res.status = ST_FOUND;
                        end
                    end else begin
                        res.status = ST_NO_ENTRY;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, t_out_word got, t_out_word want);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] %0s: got st=%0d g=%0d e=%0d, want st=%0d g=%0d e=%0d",
                     $realtime, what, got.status, got.group_index, got.entry_index,
                     want.status, want.group_index, want.entry_index);
        end
        mismatches++;
    endtask

    // predict on accepted requests, check accepted result words
    always @(posedge clk) begin
        t_out_word pred;
        t_out_word want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                pred = table_update(in_word);
                if (in_typed) pending_results.push_back(in_want);
                else pending_results.push_back(pred);
            end
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", out_word, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_word.status !== want.status ||
                        out_word.group_index !== want.group_index ||
                        out_word.entry_index !== want.entry_index) begin
                        report_mismatch("result word mismatch", out_word, want);
                    end
                end
                status_seen[out_word.status]++;
                results_checked++;
            end
        end
    end

    // receiver stalls: calm, light and heavy stretches, now and then a long hold
    initial begin
        int mode;
        int len;
        forever begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(50, 300);
            repeat (len) begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 15);
                    default: out_stall <= ($urandom_range(0, 99) < 50);
                endcase
            end
            if ($urandom_range(0, 5) == 0) begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
        end
    end

    function automatic t_dir_row dir_row(t_opcode op, logic [KEY_W-1:0] gkey,
                                         logic [KEY_W-1:0] ekey, bit typed,
                                         t_status st, int gi, int ei);
        t_dir_row row;
        row.op = op;
        row.gkey = gkey;
        row.ekey = ekey;
        row.typed = typed;
        row.want.status = st;
        row.want.group_index = IDX_OUT'(gi);
        row.want.entry_index = IDX_OUT'(ei);
        return row;
    endfunction

    // gap after a word: mostly none, some short, a few long
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random request aimed mostly at one group name
    function automatic t_in_word random_request(t_mix mix, int focus);
        t_in_word w;
        int       r;
        int       r2;
        w = '0;
        r = $urandom_range(0, 99);
        r2 = $urandom_range(0, 99);
        w.group_key = ($urandom_range(0, 3) != 0) ? grp_pool[focus]
                                                   : grp_pool[$urandom_range(0, GRP_POOL-1)];
        w.entry_key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                   : ent_pool[$urandom_range(0, ENT_POOL-1)];
        if (r < 8) begin
            // noise: any opcode, unknown keys
            w.opcode = 2'($urandom_range(0, 3));
            w.group_key = {$urandom, $urandom};
            w.entry_key = {$urandom, $urandom};
        end else if (r < 14) begin
            w.opcode = OP_CREATE;
        end else begin
            case (mix)
                MIX_FILL:  w.opcode = (r2 < 70) ? OP_ADD : (r2 < 85) ? OP_SEARCH : OP_DELETE;
                MIX_DRAIN: w.opcode = (r2 < 15) ? OP_ADD : (r2 < 40) ? OP_SEARCH : OP_DELETE;
                default:   w.opcode = (r2 < 34) ? OP_ADD : (r2 < 67) ? OP_SEARCH : OP_DELETE;
            endcase
        end
        return w;
    endfunction

    // hold one word until it is taken
    task automatic send_request(t_in_word w, bit typed, t_out_word want);
        in_valid <= 1'b1;
        in_word  <= w;
        in_typed <= typed;
        in_want  <= want;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // sender pauses until every expected result word is back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // stimulus and end of run
    initial begin
        t_in_word w;
        t_mix     mix;
        int       focus;
        int       batch_len;
        int       waited;
        bit       burst;
        int       i;

        for (i = 0; i < 8; i++) status_seen[i] = 0;
        grp_pool[0] = KEY_ZERO;
        grp_pool[1] = KEY_ONES;
        grp_pool[2] = GRP_A;
        grp_pool[3] = GRP_B;
        for (i = 4; i < GRP_POOL; i++) grp_pool[i] = {$urandom, $urandom};
        ent_pool[0] = KEY_ZERO;
        ent_pool[1] = KEY_ONES;
        ent_pool[2] = ENT_X;
        ent_pool[3] = ENT_Y;
        for (i = 4; i < ENT_POOL; i++) ent_pool[i] = {$urandom, $urandom};

        dir_rows = '{
            // empty table: every lookup misses the group
            dir_row(OP_SEARCH, GRP_A,    ENT_X,    1'b1, ST_NO_GROUP, 0, 0),
            dir_row(OP_ADD,    GRP_A,    ENT_X,    1'b1, ST_NO_GROUP, 0, 0),
            dir_row(OP_DELETE, GRP_A,    ENT_X,    1'b1, ST_NO_GROUP, 0, 0),
            // extreme group names
            dir_row(OP_CREATE, KEY_ZERO, KEY_ONES, 1'b1, ST_CREATED,  0, 0),
            dir_row(OP_CREATE, KEY_ONES, KEY_ZERO, 1'b1, ST_CREATED,  1, 0),
            dir_row(OP_CREATE, GRP_A,    ENT_X,    1'b1, ST_CREATED,  2, 0),
            // extreme entry names
            dir_row(OP_ADD,    KEY_ZERO, KEY_ONES, 1'b1, ST_ADDED,    0, 0),
            dir_row(OP_ADD,    KEY_ZERO, KEY_ZERO, 1'b1, ST_ADDED,    0, 1),
            dir_row(OP_ADD,    KEY_ZERO, ENT_X,    1'b1, ST_ADDED,    0, 2),
            dir_row(OP_SEARCH, KEY_ZERO, KEY_ZERO, 1'b1, ST_FOUND,    0, 1),
            dir_row(OP_SEARCH, KEY_ZERO, ENT_Y,    1'b1, ST_NO_ENTRY, 0, 0),
            // delete moves the last entry down, then delete of the last slot
            dir_row(OP_DELETE, KEY_ZERO, KEY_ONES, 1'b1, ST_DELETED,  0, 0),
            dir_row(OP_SEARCH, KEY_ZERO, ENT_X,    1'b0, ST_CREATED,  0, 0),
            dir_row(OP_DELETE, KEY_ZERO, KEY_ZERO, 1'b0, ST_CREATED,  0, 0),
            dir_row(OP_SEARCH, KEY_ZERO, KEY_ZERO, 1'b0, ST_CREATED,  0, 0),
            // duplicate group and entry names resolve to the lowest index
            dir_row(OP_CREATE, GRP_A,    ENT_Y,    1'b1, ST_CREATED,  3, 0),
            dir_row(OP_ADD,    GRP_A,    ENT_Y,    1'b0, ST_CREATED,  0, 0),
            dir_row(OP_ADD,    GRP_A,    ENT_Y,    1'b0, ST_CREATED,  0, 0),
            dir_row(OP_SEARCH, GRP_A,    ENT_Y,    1'b0, ST_CREATED,  0, 0),
            dir_row(OP_DELETE, GRP_A,    ENT_Y,    1'b0, ST_CREATED,  0, 0),
            dir_row(OP_ADD,    KEY_ONES, KEY_ONES, 1'b0, ST_CREATED,  0, 0),
            dir_row(OP_DELETE, KEY_ONES, ENT_Y,    1'b1, ST_NO_ENTRY, 1, 0),
            dir_row(OP_SEARCH, GRP_B,    ENT_X,    1'b1, ST_NO_GROUP, 0, 0)
        };

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < DIR_ROWS; i++) begin
            w.opcode = dir_rows[i].op;
            w.group_key = dir_rows[i].gkey;
            w.entry_key = dir_rows[i].ekey;
            send_request(w, dir_rows[i].typed, dir_rows[i].want);
            idle_gap(pick_gap(1'b0));
        end
        wait_all_results();

        // random batches
        while (random_sent < RANDOM_ITEMS) begin
            batch_len = $urandom_range(20, 60);
            mix = t_mix'($urandom_range(0, 2));
            focus = $urandom_range(0, GRP_POOL-1);
            burst = ($urandom_range(0, 4) == 0);
            repeat (batch_len) begin
                send_request(random_request(mix, focus), 1'b0, '0);
                random_sent++;
                idle_gap(pick_gap(burst));
            end
            if ($urandom_range(0, 7) == 0) wait_all_results();
        end
        in_valid <= 1'b0;

        // drain, then watch for stray words
        waited = 0;
        @(posedge clk);
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (pending_results.size() != 0) begin
            report_mismatch("result word never came", '0, pending_results[0]);
        end

        $display("covered %0d directed and %0d random requests, %0d result words checked",
                 DIR_ROWS, random_sent, results_checked);
        $display("status mix: created %0d added %0d deleted %0d found %0d %0s %0d %0s %0d %0s %0d",
                 status_seen[ST_CREATED], status_seen[ST_ADDED], status_seen[ST_DELETED],
                 status_seen[ST_FOUND], "groups-full", status_seen[ST_GROUPS_FULL],
                 "group-miss/full", status_seen[ST_NO_GROUP],
                 "entry-miss", status_seen[ST_NO_ENTRY]);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
